FILE: sv/sbgc_pkg.sv
package sbgc_pkg;

  // Field widths fixed by the word formats
  localparam int IndexBits        = 12;
  localparam int GridDimBits      = 12;
  localparam int RangeBits        = 16;
  localparam int AngleBits        = 16;
  localparam int MagBits          = 15;   // Q1.14 magnitude, 0..16384
  localparam int SineDepthDefault = 1024;

  // pi/2 in Q30
  localparam longint HalfPiQ30 = 64'sd1686629713;

  // Register reset values
  localparam logic [31:0] RotRowXReset   = 32'h0000_4000;
  localparam logic [31:0] RotRowYReset   = 32'h4000_0000;
  localparam logic [31:0] CellScaleReset = 32'd335544;

  // Register map
  typedef enum logic [2:0] {
    RegAngleStart = 3'd0,
    RegAngleStep  = 3'd1,
    RegRotRowX    = 3'd2,
    RegRotRowY    = 3'd3,
    RegOffsetX    = 3'd4,
    RegOffsetY    = 3'd5,
    RegCellScale  = 3'd6,
    RegGridSize   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic        [31:0] grid_size;
    logic        [31:0] cell_scale;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_x;
    logic        [31:0] rot_row_y;
    logic        [31:0] rot_row_x;
    logic signed [15:0] angle_step;
    logic        [15:0] angle_start;
  } cfg_t;

  // Input word
  typedef struct packed {
    logic [IndexBits-1:0] beam_index;
    logic [RangeBits-1:0] range_mm;
  } beam_t;

  // Output word
  typedef struct packed {
    logic                   in_bounds;
    logic [GridDimBits-1:0] cell_x;
    logic [GridDimBits-1:0] cell_y;
  } hit_t;

  // Table lookups: magnitude at idx and at depth - idx
  typedef struct packed {
    logic [1:0]           quad;
    logic [MagBits-1:0]   mag_fwd;
    logic [MagBits-1:0]   mag_rev;
    logic [RangeBits-1:0] range_mm;
  } trig_t;

  // Map-frame point, mm in Q28
  typedef struct packed {
    logic signed [60:0] px;
    logic signed [60:0] py;
  } point_t;

endpackage

FILE: sv/sbgc_sine_rom.sv
module sbgc_sine_rom #(
  parameter int Depth    = sbgc_pkg::SineDepthDefault,
  parameter int AddrBits = $clog2(Depth + 1)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [AddrBits-1:0]          addr_a,
  input  logic [AddrBits-1:0]          addr_b,
  output logic [sbgc_pkg::MagBits-1:0] q_a,
  output logic [sbgc_pkg::MagBits-1:0] q_b
);

  logic [sbgc_pkg::MagBits-1:0] rom [Depth+1];

  // Quarter sine, Taylor series in Q30 rounded to Q14, built at elaboration
  for (genvar k = 0; k <= Depth; k++) begin : g_entry
    localparam longint X   = (sbgc_pkg::HalfPiQ30 * longint'(k)) / Depth;
    localparam longint X2  = (X * X) >>> 30;
    localparam longint T1  = ((X  * X2) >>> 30) / 6;
    localparam longint T2  = ((T1 * X2) >>> 30) / 20;
    localparam longint T3  = ((T2 * X2) >>> 30) / 42;
    localparam longint T4  = ((T3 * X2) >>> 30) / 72;
    localparam longint T5  = ((T4 * X2) >>> 30) / 110;
    localparam longint T6  = ((T5 * X2) >>> 30) / 156;
    localparam longint T7  = ((T6 * X2) >>> 30) / 210;
    localparam longint T8  = ((T7 * X2) >>> 30) / 272;
    localparam longint Sum = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8;
    localparam longint Pos = (Sum < 0) ? 64'sd0 : Sum;
    localparam longint Val = (Pos + 64'sd32768) >>> 16;
    assign rom[k] = sbgc_pkg::MagBits'(Val);
  end

  // Two registered read ports
  always_ff @(posedge clk) begin
    if (en) begin
      q_a <= rom[addr_a];
      q_b <= rom[addr_b];
    end
  end

endmodule

FILE: sv/sbgc_angle.sv
module sbgc_angle #(
  parameter int SineDepth = sbgc_pkg::SineDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  sbgc_pkg::cfg_t  cfg,
  input  sbgc_pkg::beam_t up_data,
  input  logic            up_valid,
  output logic            up_ready,
  output sbgc_pkg::trig_t dn_data,
  output logic            dn_valid,
  input  logic            dn_ready
);

  localparam int AddrBits  = $clog2(SineDepth + 1);
  localparam int PhaseBits = 14;
  localparam int ProdBits  = PhaseBits + AddrBits;

  logic [2:0] v;
  logic [2:0] load;

  logic [31:0]                     step_prod;
  logic [15:0]                     step_bits;
  logic [sbgc_pkg::AngleBits-1:0]  angle;
  logic [sbgc_pkg::RangeBits-1:0]  range1, range2, range3;
  logic [ProdBits-1:0]             idx_prod;
  logic [AddrBits-1:0]             ti;
  logic [1:0]                      quad2, quad3;
  logic [sbgc_pkg::MagBits-1:0]    mag_fwd, mag_rev;

  // Stage advance chain
  assign load[2]  = !v[2] || dn_ready;
  assign load[1]  = !v[1] || load[2];
  assign load[0]  = !v[0] || load[1];
  assign up_ready = load[0];
  assign dn_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) v[0] <= up_valid;
      if (load[1]) v[1] <= v[0];
      if (load[2]) v[2] <= v[1];
    end
  end

  // Stage 1: beam angle, wraps modulo one turn
  assign step_bits = cfg.angle_step;
  assign step_prod = 32'(step_bits) * 32'(up_data.beam_index);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      angle  <= cfg.angle_start + step_prod[15:0];
      range1 <= up_data.range_mm;
    end
  end

  // Stage 2: quadrant and table index
  assign idx_prod = ProdBits'(angle[PhaseBits-1:0]) * ProdBits'(SineDepth);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      ti     <= idx_prod[PhaseBits +: AddrBits];
      quad2  <= angle[15:14];
      range2 <= range1;
    end
  end

  // Stage 3: table read at idx and at depth - idx
  sbgc_sine_rom #(
    .Depth    (SineDepth),
    .AddrBits (AddrBits)
  ) u_rom (
    .clk    (clk),
    .en     (load[2]),
    .addr_a (ti),
    .addr_b (AddrBits'(SineDepth) - ti),
    .q_a    (mag_fwd),
    .q_b    (mag_rev)
  );

  always_ff @(posedge clk) begin
    if (load[2]) begin
      quad3  <= quad2;
      range3 <= range2;
    end
  end

  assign dn_data.quad     = quad3;
  assign dn_data.mag_fwd  = mag_fwd;
  assign dn_data.mag_rev  = mag_rev;
  assign dn_data.range_mm = range3;

endmodule

FILE: sv/sbgc_xform.sv
module sbgc_xform (
  input  logic             clk,
  input  logic             rst,
  input  sbgc_pkg::cfg_t   cfg,
  input  sbgc_pkg::trig_t  up_data,
  input  logic             up_valid,
  output logic             up_ready,
  output sbgc_pkg::point_t dn_data,
  output logic             dn_valid,
  input  logic             dn_ready
);

  localparam int MagBits = sbgc_pkg::MagBits;

  logic [3:0] v;
  logic [3:0] load;

  logic [MagBits-1:0]        sin_mag, cos_mag;
  logic                      sin_neg, cos_neg;
  logic signed [MagBits:0]   sin_val, cos_val;
  logic signed [16:0]        range_s;
  logic signed [32:0]        lx_full, ly_full;
  logic signed [31:0]        lx, ly;
  logic signed [47:0]        p_xx, p_xy, p_yx, p_yy;
  logic signed [48:0]        sum_x, sum_y;
  logic signed [59:0]        off_x, off_y;
  logic signed [60:0]        px, py;

  // Stage advance chain
  assign load[3]  = !v[3] || dn_ready;
  assign load[2]  = !v[2] || load[3];
  assign load[1]  = !v[1] || load[2];
  assign load[0]  = !v[0] || load[1];
  assign up_ready = load[0];
  assign dn_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) v[0] <= up_valid;
      if (load[1]) v[1] <= v[0];
      if (load[2]) v[2] <= v[1];
      if (load[3]) v[3] <= v[2];
    end
  end

  // Stage 1: signed sine and cosine, laser-frame point in Q14
  // cos is the sine of the next quadrant
  assign sin_mag = up_data.quad[0] ? up_data.mag_rev : up_data.mag_fwd;
  assign cos_mag = up_data.quad[0] ? up_data.mag_fwd : up_data.mag_rev;
  assign sin_neg = up_data.quad[1];
  assign cos_neg = up_data.quad[1] ^ up_data.quad[0];
  assign sin_val = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  assign range_s = $signed({1'b0, up_data.range_mm});
  assign lx_full = range_s * cos_val;
  assign ly_full = range_s * sin_val;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      lx <= lx_full[31:0];
      ly <= ly_full[31:0];
    end
  end

  // Stage 2: rotation products, Q28
  always_ff @(posedge clk) begin
    if (load[1]) begin
      p_xx <= $signed(cfg.rot_row_x[15:0])  * lx;
      p_xy <= $signed(cfg.rot_row_x[31:16]) * ly;
      p_yx <= $signed(cfg.rot_row_y[15:0])  * lx;
      p_yy <= $signed(cfg.rot_row_y[31:16]) * ly;
    end
  end

  // Stage 3: row sums
  always_ff @(posedge clk) begin
    if (load[2]) begin
      sum_x <= 49'(p_xx) + 49'(p_xy);
      sum_y <= 49'(p_yx) + 49'(p_yy);
    end
  end

  // Stage 4: add offset scaled to Q28
  assign off_x = $signed({cfg.offset_x, 28'b0});
  assign off_y = $signed({cfg.offset_y, 28'b0});

  always_ff @(posedge clk) begin
    if (load[3]) begin
      px <= 61'(sum_x) + 61'(off_x);
      py <= 61'(sum_y) + 61'(off_y);
    end
  end

  assign dn_data.px = px;
  assign dn_data.py = py;

endmodule

FILE: sv/sbgc_cell.sv
module sbgc_cell (
  input  logic             clk,
  input  logic             rst,
  input  sbgc_pkg::cfg_t   cfg,
  input  sbgc_pkg::point_t up_data,
  input  logic             up_valid,
  output logic             up_ready,
  output sbgc_pkg::hit_t   dn_data,
  output logic             dn_valid,
  input  logic             dn_ready
);

  localparam int GridDimBits = sbgc_pkg::GridDimBits;
  localparam logic [16:0] GridLim = 17'(1) << GridDimBits;

  logic [2:0] v;
  logic [2:0] load;

  logic [59:0] mag_x, mag_y;
  logic [59:0] a_x, a_y;
  logic [63:0] b_x, b_y;
  logic        neg1, neg2;
  logic [60:0] sum_x, sum_y;
  logic [40:0] cx, cy;
  logic [16:0] width, height;
  logic        hit;
  sbgc_pkg::hit_t hit_q;

  // Stage advance chain
  assign load[2]  = !v[2] || dn_ready;
  assign load[1]  = !v[1] || load[2];
  assign load[0]  = !v[0] || load[1];
  assign up_ready = load[0];
  assign dn_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) v[0] <= up_valid;
      if (load[1]) v[1] <= v[0];
      if (load[2]) v[2] <= v[1];
    end
  end

  // Stage 1: split products, high 28-bit and low 32-bit halves times scale
  assign mag_x = up_data.px[59:0];
  assign mag_y = up_data.py[59:0];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a_x  <= mag_x[59:32] * cfg.cell_scale;
      b_x  <= mag_x[31:0]  * cfg.cell_scale;
      a_y  <= mag_y[59:32] * cfg.cell_scale;
      b_y  <= mag_y[31:0]  * cfg.cell_scale;
      neg1 <= up_data.px[60] || up_data.py[60];
    end
  end

  // Stage 2: combine halves, drop the Q52 fraction
  assign sum_x = 61'(a_x) + 61'(b_x[63:32]);
  assign sum_y = 61'(a_y) + 61'(b_y[63:32]);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      cx   <= sum_x[60:20];
      cy   <= sum_y[60:20];
      neg2 <= neg1;
    end
  end

  // Stage 3: bounds test against the clamped grid size
  assign width  = (17'(cfg.grid_size[15:0])  > GridLim) ? GridLim : 17'(cfg.grid_size[15:0]);
  assign height = (17'(cfg.grid_size[31:16]) > GridLim) ? GridLim : 17'(cfg.grid_size[31:16]);
  assign hit    = !neg2 && (cx < 41'(width)) && (cy < 41'(height));

  always_ff @(posedge clk) begin
    if (load[2]) begin
      hit_q.in_bounds <= hit;
      hit_q.cell_x    <= hit ? cx[GridDimBits-1:0] : '0;
      hit_q.cell_y    <= hit ? cy[GridDimBits-1:0] : '0;
    end
  end

  assign dn_data = hit_q;

endmodule

FILE: sv/scan_beam_to_grid_cell.sv
// Maps one laser beam (index, range in mm) to an occupancy-grid cell. The beam
// angle is angle_start + angle_step * index in 2^-16 turns; sine and cosine come
// from a quarter-wave table, the beam end point is rotated, offset and scaled by
// the reciprocal cell size, then tested against the grid size. One beam is taken
// every cycle while the output is not stalled, and each gives exactly one hit
// word. The ten register stages (angle, index, table
// read, projection, rotation products, row sums, offset add, scale products,
// truncation, bounds test) each advance on their own, so bubbles are squeezed
// out during an output stall. The sine table has SINE_TABLE_DEPTH + 1 entries
// and is read at two addresses in one cycle. Registers are written through the
// cfg port, which is always ready; write them only while no beam is in flight.
module scan_beam_to_grid_cell #(
  parameter int SINE_TABLE_DEPTH = sbgc_pkg::SineDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sbgc_pkg::beam_t      beam,
  input  logic                 beam_valid,
  output logic                 beam_ready,
  output sbgc_pkg::hit_t       hit,
  output logic                 hit_valid,
  input  logic                 hit_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  sbgc_pkg::reg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);

  sbgc_pkg::cfg_t   cfg;
  sbgc_pkg::trig_t  trig;
  sbgc_pkg::point_t point;
  logic             trig_valid, trig_ready;
  logic             point_valid, point_ready;

  // Register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start <= '0;
      cfg.angle_step  <= '0;
      cfg.rot_row_x   <= sbgc_pkg::RotRowXReset;
      cfg.rot_row_y   <= sbgc_pkg::RotRowYReset;
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.cell_scale  <= sbgc_pkg::CellScaleReset;
      cfg.grid_size   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbgc_pkg::RegAngleStart: cfg.angle_start <= cfg_data[15:0];
        sbgc_pkg::RegAngleStep:  cfg.angle_step  <= $signed(cfg_data[15:0]);
        sbgc_pkg::RegRotRowX:    cfg.rot_row_x   <= cfg_data;
        sbgc_pkg::RegRotRowY:    cfg.rot_row_y   <= cfg_data;
        sbgc_pkg::RegOffsetX:    cfg.offset_x    <= $signed(cfg_data);
        sbgc_pkg::RegOffsetY:    cfg.offset_y    <= $signed(cfg_data);
        sbgc_pkg::RegCellScale:  cfg.cell_scale  <= cfg_data;
        sbgc_pkg::RegGridSize:   cfg.grid_size   <= cfg_data;
      endcase
    end
  end

  // Angle and table lookup
  sbgc_angle #(
    .SineDepth (SINE_TABLE_DEPTH)
  ) u_angle (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_data  (beam),
    .up_valid (beam_valid),
    .up_ready (beam_ready),
    .dn_data  (trig),
    .dn_valid (trig_valid),
    .dn_ready (trig_ready)
  );

  // Projection, rotation and offset
  sbgc_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_data  (trig),
    .up_valid (trig_valid),
    .up_ready (trig_ready),
    .dn_data  (point),
    .dn_valid (point_valid),
    .dn_ready (point_ready)
  );

  // Cell scaling and bounds
  sbgc_cell u_cell (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_data  (point),
    .up_valid (point_valid),
    .up_ready (point_ready),
    .dn_data  (hit),
    .dn_valid (hit_valid),
    .dn_ready (hit_ready)
  );

endmodule

FILE: sim/tb_scan_beam_to_grid_cell.sv
`timescale 1ns / 100ps

module tb_scan_beam_to_grid_cell;
  import sbgc_pkg::*;

  localparam int TableDepth = SineDepthDefault;
  localparam int NumSettings = 6;
  localparam int RandomBeams = 100;

  // Tracks register state, predicts the cell of each accepted beam and checks hits
  class cell_scoreboard;
    bit [15:0] angle_start;
    bit [15:0] angle_step;
    bit [31:0] rot_row_x;
    bit [31:0] rot_row_y;
    bit [31:0] offset_x;
    bit [31:0] offset_y;
    bit [31:0] cell_scale;
    bit [31:0] grid_size;
    longint quarter_mag[TableDepth+1];
    hit_t expected_cells[$];
    int beams_noted;
    int hits_inside;
    int hits_outside;
    int errors;

    function new();
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      bit [63:0] den;
      bit [63:0] half_pi;
      longint sum;
      half_pi = HalfPiQ30;
      angle_start = '0;
      angle_step = '0;
      rot_row_x = RotRowXReset;
      rot_row_y = RotRowYReset;
      offset_x = '0;
      offset_y = '0;
      cell_scale = CellScaleReset;
      grid_size = '0;
      beams_noted = 0;
      hits_inside = 0;
      hits_outside = 0;
      errors = 0;
      // Quarter-wave sine: Taylor series in Q30, rounded half up to Q14
      for (int k = 0; k <= TableDepth; k++) begin
        x = (half_pi * 64'(k)) / 64'(TableDepth);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 8; n++) begin
          den = 64'((2 * n) * (2 * n + 1));
          term = ((term * x2) >> 30) / den;
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        quarter_mag[k] = (sum + 32768) >>> 16;
      end
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] data);
      case (idx)
        RegAngleStart: angle_start = data[15:0];
        RegAngleStep:  angle_step = data[15:0];
        RegRotRowX:    rot_row_x = data;
        RegRotRowY:    rot_row_y = data;
        RegOffsetX:    offset_x = data;
        RegOffsetY:    offset_y = data;
        RegCellScale:  cell_scale = data;
        RegGridSize:   grid_size = data;
        default: ;
      endcase
    endfunction

    function longint sine_at(bit [1:0] quad, int ti);
      longint v;
      v = quad[0] ? quarter_mag[TableDepth - ti] : quarter_mag[ti];
      return quad[1] ? -v : v;
    endfunction

    function longint sx16(bit [15:0] v);
      return longint'($signed(v));
    endfunction

    // floor(p * scale / 2^52), split to stay within 64 bits
    function bit [63:0] cell_of(longint p);
      bit [63:0] up;
      bit [63:0] s;
      up = p;
      s = cell_scale;
      return ((up >> 32) * s + (((up & 64'hFFFF_FFFF) * s) >> 32)) >> 20;
    endfunction

    function void note_beam(beam_t b);
      bit [15:0] ang;
      bit [1:0] quad;
      bit [1:0] quad_cos;
      int ti;
      longint rng;
      longint lx;
      longint ly;
      longint px;
      longint py;
      bit [63:0] cx;
      bit [63:0] cy;
      bit [63:0] w;
      bit [63:0] h;
      bit [63:0] lim;
      hit_t pred;
      ang = angle_start + angle_step * b.beam_index;
      quad = ang[15:14];
      quad_cos = quad + 2'd1;
      ti = (int'(ang[13:0]) * TableDepth) >> 14;
      rng = longint'(b.range_mm);
      lx = rng * sine_at(quad_cos, ti);
      ly = rng * sine_at(quad, ti);
      px = sx16(rot_row_x[15:0]) * lx + sx16(rot_row_x[31:16]) * ly
         + longint'($signed(offset_x)) * (longint'(1) << 28);
      py = sx16(rot_row_y[15:0]) * lx + sx16(rot_row_y[31:16]) * ly
         + longint'($signed(offset_y)) * (longint'(1) << 28);
      pred = '0;
      if (px >= 0 && py >= 0) begin
        cx = cell_of(px);
        cy = cell_of(py);
        lim = 64'd1 << GridDimBits;
        w = grid_size[15:0];
        h = grid_size[31:16];
        if (w > lim) w = lim;
        if (h > lim) h = lim;
        if (cx < w && cy < h) begin
          pred.in_bounds = 1'b1;
          pred.cell_x = cx[GridDimBits-1:0];
          pred.cell_y = cy[GridDimBits-1:0];
        end
      end
      expected_cells.push_back(pred);
      beams_noted++;
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      if (expected_cells.size() == 0) begin
        $error("hit word with no beam pending: in_bounds %0d cell_x %0d cell_y %0d",
               got.in_bounds, got.cell_x, got.cell_y);
        errors++;
        return;
      end
      want = expected_cells.pop_front();
      if (want.in_bounds) hits_inside++;
      else hits_outside++;
      if (got.in_bounds !== want.in_bounds) begin
        $error("in_bounds mismatch: expected %0d, got %0d", want.in_bounds, got.in_bounds);
        errors++;
      end
      if (got.cell_x !== want.cell_x) begin
        $error("cell_x mismatch: expected %0d, got %0d", want.cell_x, got.cell_x);
        errors++;
      end
      if (got.cell_y !== want.cell_y) begin
        $error("cell_y mismatch: expected %0d, got %0d", want.cell_y, got.cell_y);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  beam_t      beam;
  logic       beam_valid;
  logic       beam_ready;
  hit_t       hit;
  logic       hit_valid;
  logic       hit_ready;
  logic       cfg_valid;
  logic       cfg_ready;
  reg_index_t cfg_index;
  logic [31:0] cfg_data;

  cell_scoreboard sb = new();

  int send_gap_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  scan_beam_to_grid_cell dut (
    .clk        (clk),
    .rst        (rst),
    .beam       (beam),
    .beam_valid (beam_valid),
    .beam_ready (beam_ready),
    .hit        (hit),
    .hit_valid  (hit_valid),
    .hit_ready  (hit_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (beam_valid && beam_ready) sb.note_beam(beam);
      if (hit_valid && hit_ready) sb.check_hit(hit);
    end
  end

  // Output side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hit_ready <= 1'b0;
      hold_left--;
    end else begin
      hit_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called just after a falling edge; returns just after a falling edge, once the beam has been accepted
  task automatic send_beam(int idx, int rng);
    beam_t b;
    b.beam_index = idx[IndexBits-1:0];
    b.range_mm = rng[RangeBits-1:0];
    while ($urandom_range(99) < send_gap_pct) begin
      beam_valid <= 1'b0;
      @(negedge clk);
    end
    beam <= b;
    beam_valid <= 1'b1;
    do @(posedge clk); while (!beam_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_q14();
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  // One full register set; which picks a nominal or extreme directed set, or a random flavor
  task automatic program_setting(int which);
    logic [31:0] regs [8];
    longint w;
    longint h;
    longint sc;
    w = $urandom_range(16, 4095);
    h = $urandom_range(16, 4095);
    sc = $urandom_range(20000, 3355443);
    if (which == 4) w = 0;
    if (which == 5) begin
      w = $urandom_range(4097, 65535);
      h = $urandom_range(4097, 65535);
      sc = $urandom_range(1677722, 16777216);
    end
    // random flavor: laser origin near the grid center, random rotation and angles
    regs[RegAngleStart] = $urandom_range(0, 65535);
    regs[RegAngleStep]  = $urandom_range(0, 65535);
    regs[RegRotRowX]    = {rand_q14(), rand_q14()};
    regs[RegRotRowY]    = {rand_q14(), rand_q14()};
    regs[RegOffsetX]    = 32'((w * 64'd8388608) / sc + $urandom_range(0, 2000) - 1000);
    regs[RegOffsetY]    = 32'((h * 64'd8388608) / sc + $urandom_range(0, 2000) - 1000);
    regs[RegCellScale]  = 32'(sc);
    regs[RegGridSize]   = {h[15:0], w[15:0]};
    case (which)
      0: begin
        // identity rotation, 50 mm cells, 2000 x 2000 grid centered at 50 m
        regs[RegAngleStart] = 32'h0000;
        regs[RegAngleStep]  = 32'd16;
        regs[RegRotRowX]    = 32'h0000_4000;
        regs[RegRotRowY]    = 32'h4000_0000;
        regs[RegOffsetX]    = 32'd50000;
        regs[RegOffsetY]    = 32'd50000;
        regs[RegCellScale]  = 32'd335544;
        regs[RegGridSize]   = 32'h07D0_07D0;
      end
      1: begin
        // every register at an extreme
        regs[RegAngleStart] = 32'hFFFF;
        regs[RegAngleStep]  = 32'h8000;
        regs[RegRotRowX]    = 32'h8000_7FFF;
        regs[RegRotRowY]    = 32'h7FFF_8000;
        regs[RegOffsetX]    = 32'h7FFF_FFFF;
        regs[RegOffsetY]    = 32'h8000_0000;
        regs[RegCellScale]  = 32'hFFFF_FFFF;
        regs[RegGridSize]   = 32'hFFFF_FFFF;
      end
      3: begin
        // zero cell scale on a 1 x 1 grid: only cell 0 can hit
        regs[RegAngleStart] = 32'h3FFF;
        regs[RegAngleStep]  = 32'h7FFF;
        regs[RegRotRowX]    = 32'h0000_C000;
        regs[RegRotRowY]    = 32'hC000_0000;
        regs[RegOffsetX]    = 32'h7FFF_FFFF;
        regs[RegOffsetY]    = 32'h7FFF_FFFF;
        regs[RegCellScale]  = 32'h0000_0000;
        regs[RegGridSize]   = 32'h0001_0001;
      end
      default: ;
    endcase
    write_reg(RegAngleStart, regs[RegAngleStart]);
    write_reg(RegAngleStep, regs[RegAngleStep]);
    write_reg(RegRotRowX, regs[RegRotRowX]);
    write_reg(RegRotRowY, regs[RegRotRowY]);
    write_reg(RegOffsetX, regs[RegOffsetX]);
    write_reg(RegOffsetY, regs[RegOffsetY]);
    write_reg(RegCellScale, regs[RegCellScale]);
    write_reg(RegGridSize, regs[RegGridSize]);
    cfg_valid <= 1'b0;
  endtask

  // Beams on quadrant edges, range extremes, off-grid and negative points
  task automatic send_directed();
    send_beam(0, 0);
    send_beam(0, 65535);
    send_beam(0, 40000);
    send_beam(1024, 40000);
    send_beam(2048, 40000);
    send_beam(3072, 40000);
    send_beam(2048, 60000);
    send_beam(3072, 60000);
    send_beam(4095, 65535);
    send_beam(4095, 0);
    send_beam(512, 30000);
    send_beam(1536, 30000);
    send_beam(2560, 30000);
    send_beam(3584, 30000);
    send_beam(1, 1);
    send_beam(2047, 65535);
    send_beam(1023, 12345);
    send_beam(3000, 50000);
    send_beam(100, 65535);
    send_beam(2730, 21845);
  endtask

  initial begin
    rst = 1'b1;
    beam = '0;
    beam_valid = 1'b0;
    hit_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegAngleStart;
    cfg_data = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int s = 0; s < NumSettings; s++) begin
      if (s < 2) begin
        send_gap_pct = 34;
        recv_stall_pct = 47;
      end else if (s < 4) begin
        send_gap_pct = 47;
        recv_stall_pct = 34;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      program_setting(s);
      if (s == 0) begin
        send_directed();
        // long output stall with the input pushing: block must back up
        send_gap_pct = 0;
        hold_request = 90;
        for (int i = 0; i < 40; i++)
          send_beam($urandom_range(0, 4095), $urandom_range(0, 65535));
        send_gap_pct = 34;
        // pause the input until every hit is back
        beam_valid <= 1'b0;
        wait_drained();
      end
      for (int i = 0; i < RandomBeams; i++)
        send_beam($urandom_range(0, 4095), $urandom_range(0, 65535));
      beam_valid <= 1'b0;
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (sb.pending() > 0) begin
      $error("%0d hit words never arrived", sb.pending());
      sb.errors++;
    end
    $display("Ran %0d beams through %0d register sets, idle mixes and a long output stall.",
             sb.beams_noted, NumSettings);
    $display("Hits checked: %0d inside the grid, %0d outside.",
             sb.hits_inside, sb.hits_outside);
    if (sb.errors == 0) begin
      $display("scan_beam_to_grid_cell test passed");
    end else begin
      $display("scan_beam_to_grid_cell test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2400000;
    $display("scan_beam_to_grid_cell test failed");
    $finish;
  end

endmodule
